// ----- design/gcm_pkg.sv -----
// Package with shared types and constants for the multi-window GC content core.
package gcm_pkg;

  // History and delay ring geometry for a 1000-base half width.
  localparam int MaxHalfWidth = 1000;
  localparam int HistDepth    = 2 * MaxHalfWidth + 1;
  localparam int DelayDepth   = MaxHalfWidth + 1;
  localparam int NumWindows   = 9;
  localparam int HistAw       = $clog2(HistDepth);
  localparam int DelayAw      = $clog2(DelayDepth);
  localparam int SumW         = 11;
  localparam int GcW          = 14;
  localparam int NumW         = 26;

  // Scale for hundredths of a percent, doubled for half-up rounding.
  localparam logic [14:0] GcScale = 15'd20000;

  // Input operation codes.
  localparam logic OpPush  = 1'b0;
  localparam logic OpDrain = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // Half width of each window, smallest first.
  function automatic logic [SumW-1:0] half_width(input logic [3:0] k);
    logic [SumW-1:0] h;
    case (k)
      4'd0:    h = 11'd1;
      4'd1:    h = 11'd2;
      4'd2:    h = 11'd5;
      4'd3:    h = 11'd25;
      4'd4:    h = 11'd50;
      4'd5:    h = 11'd100;
      4'd6:    h = 11'd250;
      4'd7:    h = 11'd500;
      4'd8:    h = 11'd1000;
      default: h = 11'd1000;
    endcase
    return h;
  endfunction

endpackage

// ----- design/gc_content_multi_window_core.sv -----
// Sliding-window GC content core with nine centered windows and a shared divider.
//
// Each transaction carries one base character or a drain tick. A push that does
// not produce a result is taken while the core stays idle. A push once 1000
// bases are in, and every drain tick with a pending position, produces one
// result: each of the nine windows in turn passes a setup state, a multiply
// state and the shared restoring divider, and the result then waits in
// the output register until taken. Results lag the input by 1000 positions; after
// the last base, drain ticks flush the remaining positions, and the one flagged
// final_position returns the core to its reset state. The history rings are only
// read at positions written in the current sequence, so they need no clearing.
module gc_content_multi_window_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  base_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] position,
  output logic [7:0]  center_base,
  output logic [13:0] gc_w3,
  output logic [13:0] gc_w5,
  output logic [13:0] gc_w11,
  output logic [13:0] gc_w51,
  output logic [13:0] gc_w101,
  output logic [13:0] gc_w201,
  output logic [13:0] gc_w501,
  output logic [13:0] gc_w1001,
  output logic [13:0] gc_w2001,
  output logic        final_position
);

  gcm_pkg::state_t state, state_next;

  logic                        hist_mem [gcm_pkg::HistDepth];
  logic [7:0]                  delay_mem [gcm_pkg::DelayDepth];

  logic [31:0]                 bases_received;
  logic [31:0]                 qpos;
  logic                        draining;
  logic                        final_r;
  logic [gcm_pkg::HistAw-1:0]  hw_ptr, qh_ptr;
  logic [gcm_pkg::DelayAw-1:0] dw_ptr, qd_ptr;
  logic [gcm_pkg::SumW-1:0]    sums [gcm_pkg::NumWindows];
  logic [gcm_pkg::GcW-1:0]     gc_res [gcm_pkg::NumWindows];
  logic [3:0]                  win;
  logic [3:0]                  bit_cnt;
  logic [gcm_pkg::SumW-1:0]    n_r;
  logic                        sub_en, add_en, lo_bit, hi_bit;
  logic [gcm_pkg::NumW-1:0]    rem;
  logic [gcm_pkg::NumW-1:0]    dsh;
  logic [gcm_pkg::GcW-1:0]     quo;
  logic [7:0]                  center_r;

  // Decisions taken on an input transaction.
  logic in_acc, out_acc, is_push, push_ok, push_emit, drain_empty, clear_all;
  logic gc_bit;
  assign in_acc      = in_valid && !in_stall;
  assign out_acc     = out_valid && !out_stall;
  assign is_push     = (operation == gcm_pkg::OpPush);
  assign push_ok     = is_push && !draining && (bases_received != 32'hFFFF_FFFF);
  assign push_emit   = push_ok && (bases_received >= 32'(gcm_pkg::MaxHalfWidth));
  assign drain_empty = !is_push && (qpos >= bases_received);
  assign clear_all   = (in_acc && drain_empty) || (out_acc && final_r);
  assign gc_bit      = (base_code == 8'h63) || (base_code == 8'h43) ||
                       (base_code == 8'h67) || (base_code == 8'h47);

  // Window geometry for the window being worked on.
  logic [gcm_pkg::SumW-1:0]   h_cur;
  logic [31:0]                right_raw;
  logic [gcm_pkg::SumW-1:0]   left_n, right_n;
  logic [gcm_pkg::HistAw:0]   lo_sum, hi_sum;
  logic [gcm_pkg::HistAw-1:0] lo_addr, hi_addr;
  always_comb begin
    h_cur     = gcm_pkg::half_width(win);
    right_raw = bases_received - 32'd1 - qpos;
    left_n    = (qpos >= 32'(h_cur)) ? h_cur : qpos[gcm_pkg::SumW-1:0];
    right_n   = (right_raw >= 32'(h_cur)) ? h_cur : right_raw[gcm_pkg::SumW-1:0];
    lo_sum    = {1'b0, qh_ptr} - 12'(h_cur);
    if ({1'b0, qh_ptr} < 12'(h_cur)) begin
      lo_sum = {1'b0, qh_ptr} + 12'(gcm_pkg::HistDepth) - 12'(h_cur);
    end
    hi_sum = {1'b0, qh_ptr} + 12'd1 + 12'(h_cur);
    if (hi_sum >= 12'(gcm_pkg::HistDepth)) begin
      hi_sum = hi_sum - 12'(gcm_pkg::HistDepth);
    end
    lo_addr = lo_sum[gcm_pkg::HistAw-1:0];
    hi_addr = hi_sum[gcm_pkg::HistAw-1:0];
  end

  // One restoring divider step.
  logic                     div_take;
  logic [gcm_pkg::GcW-1:0]  quo_next;
  assign div_take = (rem >= dsh);
  assign quo_next = {quo[gcm_pkg::GcW-2:0], div_take};

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      gcm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (push_emit || (!is_push && !drain_empty)) begin
            state_next = gcm_pkg::ST_SETUP;
          end
        end
      end
      gcm_pkg::ST_SETUP: state_next = gcm_pkg::ST_LOAD;
      gcm_pkg::ST_LOAD:  state_next = gcm_pkg::ST_DIV;
      gcm_pkg::ST_DIV: begin
        if (bit_cnt == 4'(gcm_pkg::GcW - 1)) begin
          state_next = (win == 4'(gcm_pkg::NumWindows - 1)) ? gcm_pkg::ST_OUT
                                                              : gcm_pkg::ST_SETUP;
        end
      end
      gcm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = gcm_pkg::ST_IDLE;
        end
      end
      default: state_next = gcm_pkg::ST_IDLE;
    endcase
  end

  // History rings: written on a push, read by the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc && push_ok) begin
      hist_mem[hw_ptr]  <= gc_bit;
      delay_mem[dw_ptr] <= base_code;
    end
    lo_bit   <= hist_mem[lo_addr];
    hi_bit   <= hist_mem[hi_addr];
    center_r <= delay_mem[qd_ptr];
  end

  // Positions, ring pointers and mode.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      bases_received <= '0;
      qpos           <= '0;
      draining       <= 1'b0;
      final_r        <= 1'b0;
      hw_ptr         <= '0;
      qh_ptr         <= '0;
      dw_ptr         <= '0;
      qd_ptr         <= '0;
    end else begin
      if (in_acc) begin
        final_r <= 1'b0;
        if (push_ok) begin
          bases_received <= bases_received + 32'd1;
          hw_ptr <= (hw_ptr == gcm_pkg::HistAw'(gcm_pkg::HistDepth - 1)) ? '0 : hw_ptr + 1'b1;
          dw_ptr <= (dw_ptr == gcm_pkg::DelayAw'(gcm_pkg::DelayDepth - 1)) ? '0 : dw_ptr + 1'b1;
        end else if (!is_push) begin
          draining <= 1'b1;
          final_r  <= (qpos + 32'd1 == bases_received);
        end
      end
      if (out_acc) begin
        qpos   <= qpos + 32'd1;
        qh_ptr <= (qh_ptr == gcm_pkg::HistAw'(gcm_pkg::HistDepth - 1)) ? '0 : qh_ptr + 1'b1;
        qd_ptr <= (qd_ptr == gcm_pkg::DelayAw'(gcm_pkg::DelayDepth - 1)) ? '0 : qd_ptr + 1'b1;
      end
    end
  end

  // Running window sums: new base added on a push, each window slid as its dividend is loaded.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int k = 0; k < gcm_pkg::NumWindows; k++) begin
        sums[k] <= '0;
      end
    end else if (in_acc && push_ok) begin
      for (int k = 0; k < gcm_pkg::NumWindows; k++) begin
        if (bases_received - qpos <= 32'(gcm_pkg::half_width(4'(k)))) begin
          sums[k] <= sums[k] + gcm_pkg::SumW'(gc_bit);
        end
      end
    end else if (state == gcm_pkg::ST_LOAD && !final_r) begin
      sums[win] <= sums[win] - gcm_pkg::SumW'(sub_en & lo_bit)
                             + gcm_pkg::SumW'(add_en & hi_bit);
    end
  end

  // Per-window setup, multiply and shared divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      bit_cnt <= '0;
    end else begin
      case (state)
        gcm_pkg::ST_IDLE: begin
          win <= '0;
        end
        gcm_pkg::ST_SETUP: begin
          n_r    <= left_n + right_n + 11'd1;
          sub_en <= (qpos >= 32'(h_cur));
          add_en <= (right_raw > 32'(h_cur));
        end
        gcm_pkg::ST_LOAD: begin
          rem     <= gcm_pkg::NumW'(gcm_pkg::GcScale) * gcm_pkg::NumW'(sums[win])
                     + gcm_pkg::NumW'(n_r);
          dsh     <= gcm_pkg::NumW'({n_r, 1'b0}) << (gcm_pkg::GcW - 1);
          quo     <= '0;
          bit_cnt <= '0;
        end
        gcm_pkg::ST_DIV: begin
          if (div_take) begin
            rem <= rem - dsh;
          end
          dsh     <= dsh >> 1;
          quo     <= quo_next;
          bit_cnt <= bit_cnt + 4'd1;
          if (bit_cnt == 4'(gcm_pkg::GcW - 1)) begin
            gc_res[win] <= quo_next;
            win         <= win + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields.
  assign position       = qpos;
  assign center_base    = center_r;
  assign gc_w3          = gc_res[0];
  assign gc_w5          = gc_res[1];
  assign gc_w11         = gc_res[2];
  assign gc_w51         = gc_res[3];
  assign gc_w101        = gc_res[4];
  assign gc_w201        = gc_res[5];
  assign gc_w501        = gc_res[6];
  assign gc_w1001       = gc_res[7];
  assign gc_w2001       = gc_res[8];
  assign final_position = final_r;

  // A waiting result blocks new input.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a result waits");

  // The 3-, 101- and 2001-base fractions never exceed one hundred percent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gc_w3 <= 14'd10000 && gc_w2001 <= 14'd10000 && gc_w101 <= 14'd10000))
    else $error("GC fraction out of range");

  // The final result clears the sequence state.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_position) |=> (bases_received == 32'd0 && !draining))
    else $error("state not cleared after final result");

  // Output position never runs ahead of the received bases.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (qpos < bases_received))
    else $error("result position beyond received bases");

endmodule
